// File: design/mbd_pkg.sv
// shared types and constants for the 2x2 box-filter mip downsampler
// no dependencies; imported by every module of the block
`default_nettype none
package mbd_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_HEIGHT  = 4096;
	localparam int CHANNELS    = 4;
	localparam int LINE_DEPTH  = MAX_WIDTH / 2;
	localparam int QUEUE_DEPTH = 4;

	localparam int DIM_W      = $clog2(MAX_WIDTH) + 1;   // config width/height field
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int LINE_IDX_W = $clog2(LINE_DEPTH);
	localparam int CH_W       = 3;
	localparam int CFG_DATA_W = DIM_W;
	localparam int CFG_IDX_W  = 2;
	localparam int BYTE_W     = 8;
	localparam int SUM_W      = BYTE_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_CHANNELS_USED = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_index_t;

	// store: even-row pair sum into the line buffer; emit: combine with the line and output
	typedef enum logic {
		OP_STORE = 1'b0,
		OP_EMIT  = 1'b1
	} op_kind_t;

	typedef logic [CHANNELS-1:0][SUM_W-1:0] pair_sums_t;

	typedef struct packed {
		op_kind_t                kind;
		logic [LINE_IDX_W-1:0]   idx;
		pair_sums_t              sums;
		logic                    frame_end;
	} line_op_t;

endpackage
`default_nettype wire

// File: design/mbd_front.sv
// front end: config registers, raster position tracking, left-pixel hold, pair sums
// depends on mbd_pkg; produces line_op_t requests for the op queue
`default_nettype none
module mbd_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_fire,
	input  wire logic [mbd_pkg::BYTE_W-1:0]     chan_a,
	input  wire logic [mbd_pkg::BYTE_W-1:0]     chan_b,
	input  wire logic [mbd_pkg::BYTE_W-1:0]     chan_c,
	input  wire logic [mbd_pkg::BYTE_W-1:0]     chan_d,
	output logic                                push,
	output mbd_pkg::line_op_t                   push_op
);
	import mbd_pkg::*;

	logic [DIM_W-1:0] src_width_q, src_height_q;
	logic [CH_W-1:0]  chans_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CHANNELS-1:0][BYTE_W-1:0] left_q;

	logic [DIM_W-1:0] w, h, ew, eh, col_ext, row_ext, col_inc, row_inc;
	logic [CH_W-1:0]  nch;
	logic [CHANNELS-1:0][BYTE_W-1:0] raw_pix, pix;
	logic in_frame;

	assign raw_pix = {chan_d, chan_c, chan_b, chan_a};

	// clamp configuration to the supported ranges
	always_comb begin
		if (src_width_q < DIM_W'(2))
			w = DIM_W'(2);
		else if (src_width_q > DIM_W'(MAX_WIDTH))
			w = DIM_W'(MAX_WIDTH);
		else
			w = src_width_q;
		if (src_height_q < DIM_W'(2))
			h = DIM_W'(2);
		else if (src_height_q > DIM_W'(MAX_HEIGHT))
			h = DIM_W'(MAX_HEIGHT);
		else
			h = src_height_q;
		if (chans_q < CH_W'(1))
			nch = CH_W'(1);
		else if (chans_q > CH_W'(CHANNELS))
			nch = CH_W'(CHANNELS);
		else
			nch = chans_q;
	end

	assign ew       = {w[DIM_W-1:1], 1'b0};
	assign eh       = {h[DIM_W-1:1], 1'b0};
	assign col_ext  = DIM_W'(col_q);
	assign row_ext  = DIM_W'(row_q);
	assign col_inc  = col_ext + DIM_W'(1);
	assign row_inc  = row_ext + DIM_W'(1);
	assign in_frame = (col_ext < ew) && (row_ext < eh);

	// unused channels read as zero all the way through
	always_comb begin
		for (int k = 0; k < CHANNELS; k++)
			pix[k] = (CH_W'(k) < nch) ? raw_pix[k] : '0;
	end

	always_comb begin
		push_op.kind      = row_q[0] ? OP_EMIT : OP_STORE;
		push_op.idx       = col_q[COL_W-1:1];
		push_op.frame_end = (row_ext == eh - DIM_W'(1)) && (col_ext == ew - DIM_W'(1));
		for (int k = 0; k < CHANNELS; k++)
			push_op.sums[k] = SUM_W'(left_q[k]) + SUM_W'(pix[k]);
	end

	assign push = in_fire && in_frame && col_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= DIM_W'(256);
			src_height_q <= DIM_W'(256);
			chans_q      <= CH_W'(4);
			col_q        <= '0;
			row_q        <= '0;
			left_q       <= '0;
		end else if (cfg_we && reg_index_t'(cfg_index) != REG_UNUSED) begin
			unique case (reg_index_t'(cfg_index))
				REG_SOURCE_WIDTH:  src_width_q  <= cfg_data;
				REG_SOURCE_HEIGHT: src_height_q <= cfg_data;
				REG_CHANNELS_USED: chans_q      <= cfg_data[CH_W-1:0];
				default: ;
			endcase
			// a write to any of the three defined registers restarts the frame
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (in_frame && !col_q[0])
				left_q <= pix;
			if (col_inc >= w) begin
				col_q <= '0;
				if (row_inc >= h)
					row_q <= '0;
				else
					row_q <= row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// File: design/mbd_queue.sv
// short fifo of line ops between the front end and the line-buffer back end
// depends on mbd_pkg
`default_nettype none
module mbd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire mbd_pkg::line_op_t push_op,
	output logic                   full,
	input  wire logic              pop,
	output logic                   head_valid,
	output mbd_pkg::line_op_t      head_op
);
	import mbd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	line_op_t         slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/mbd_back.sv
// back end: pair-sum line buffer, 2x2 average and the output register
// depends on mbd_pkg; consumes line ops from mbd_queue
`default_nettype none
module mbd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        head_valid,
	input  wire mbd_pkg::line_op_t           head_op,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [mbd_pkg::BYTE_W-1:0]       avg_a,
	output logic [mbd_pkg::BYTE_W-1:0]       avg_b,
	output logic [mbd_pkg::BYTE_W-1:0]       avg_c,
	output logic [mbd_pkg::BYTE_W-1:0]       avg_d,
	output logic                             frame_end
);
	import mbd_pkg::*;

	pair_sums_t line_mem [LINE_DEPTH];

	logic       valid_s1;
	pair_sums_t upper_s1, lower_s1;
	logic       frame_end_s1;

	logic       out_valid_q;
	logic [CHANNELS-1:0][BYTE_W-1:0] avg_q;
	logic       frame_end_q;

	logic out_free, s1_ready, load_out;
	logic [CHANNELS-1:0][BYTE_W-1:0] avg_next;

	assign out_free = !out_valid_q || out_ready;
	assign s1_ready = !valid_s1 || out_free;
	// stores retire at the pop edge and never wait on the output side
	assign pop      = head_valid && (head_op.kind == OP_STORE || s1_ready);
	assign load_out = valid_s1 && out_free;

	always_ff @(posedge clk) begin
		if (pop && head_op.kind == OP_STORE)
			line_mem[head_op.idx] <= head_op.sums;
		if (pop && head_op.kind == OP_EMIT) begin
			upper_s1     <= line_mem[head_op.idx];
			lower_s1     <= head_op.sums;
			frame_end_s1 <= head_op.frame_end;
		end
	end

	// unused channels carry zero sums, so their average is zero
	always_comb begin
		for (int k = 0; k < CHANNELS; k++)
			avg_next[k] = BYTE_W'(({1'b0, upper_s1[k]} + {1'b0, lower_s1[k]}) >> 2);
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_q       <= avg_next;
			frame_end_q <= frame_end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready)
				valid_s1 <= pop && head_op.kind == OP_EMIT;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign avg_a     = avg_q[0];
	assign avg_b     = avg_q[1];
	assign avg_c     = avg_q[2];
	assign avg_d     = avg_q[3];
	assign frame_end = frame_end_q;

endmodule
`default_nettype wire

// File: design/mip_box_downsample_2x2_unit.sv
// top level of the 2x2 box-filter mip downsampler
// depends on mbd_pkg, mbd_front, mbd_queue, mbd_back
//
//   channel   handshake              payload
//   in        in_valid / in_ready    chan_a chan_b chan_c chan_d
//   out       out_valid / out_ready  avg_a avg_b avg_c avg_d frame_end
//   cfg       cfg_we                 cfg_index cfg_data
//
// one source pixel per clock while in_ready is high; after the edge that accepts the pixel
// completing its 2x2 block, the result passes the queue, line-buffer read and output register
// the line buffer has one write and one registered read port; no clearing pass,
// entries are always stored on an even row before the odd row reads them
// in_ready drops only when the four-entry op queue is full
`default_nettype none
module mip_box_downsample_2x2_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [mbd_pkg::BYTE_W-1:0]     chan_a,
	input  wire logic [mbd_pkg::BYTE_W-1:0]     chan_b,
	input  wire logic [mbd_pkg::BYTE_W-1:0]     chan_c,
	input  wire logic [mbd_pkg::BYTE_W-1:0]     chan_d,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [mbd_pkg::BYTE_W-1:0]          avg_a,
	output logic [mbd_pkg::BYTE_W-1:0]          avg_b,
	output logic [mbd_pkg::BYTE_W-1:0]          avg_c,
	output logic [mbd_pkg::BYTE_W-1:0]          avg_d,
	output logic                                frame_end
);
	import mbd_pkg::*;

	logic     q_full, push, pop, head_valid, in_fire;
	line_op_t push_op, head_op;

	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;

	mbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_fire  (in_fire),
		.chan_a   (chan_a),
		.chan_b   (chan_b),
		.chan_c   (chan_c),
		.chan_d   (chan_d),
		.push     (push),
		.push_op  (push_op)
	);

	mbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_op   (head_op)
	);

	mbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_op   (head_op),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.avg_a     (avg_a),
		.avg_b     (avg_b),
		.avg_c     (avg_c),
		.avg_d     (avg_d),
		.frame_end (frame_end)
	);

endmodule
`default_nettype wire
